// ----- rtl/core/rcrd_pkg.sv -----
`timescale 1ns / 1ps

package rcrd_pkg;

  localparam int WORD_W  = 16;
  localparam int LOW_W   = 11;
  localparam int CNT_W   = 5;
  localparam int CHAR_W  = 12;
  localparam int KIND_W  = 2;

  localparam logic [WORD_W-1:0] END_WORD = 16'hFFFF;

  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
  } run_ctrl_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } run_status_t;

endpackage

// ----- rtl/core/rcrd_run_unit.sv -----
`timescale 1ns / 1ps

module rcrd_run_unit
  import rcrd_pkg::*;
(
  input  logic             clk,
  input  run_ctrl_t        ctrl,
  input  logic [LOW_W-1:0] start_in,
  input  logic [CNT_W-1:0] len_in,
  output run_status_t      status
);

  logic [LOW_W-1:0] start_r;
  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] off_r;
  logic [CNT_W-1:0] off_inc;

  assign off_inc = off_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      start_r <= start_in;
      len_r   <= len_in;
      off_r   <= '0;
    end else if (ctrl.step) begin
      off_r <= off_inc;
    end
  end

  assign status.character = CHAR_W'(start_r) + CHAR_W'(off_r);
  assign status.last      = (off_inc == len_r);

endmodule

// ----- rtl/core/room_character_run_decoder_unit.sv -----
`timescale 1ns / 1ps

// Expands a packed room character table, one 16-bit word per handshake, into
// (room, character) words. A header word emits nothing, an empty-room word or
// the end word. An entry word with run length L is accepted, then emits L
// characters from the shared start-plus-offset adder of the run unit, each
// only when the output register is free; in_ready stays low during the run.
// After the end word every further word is accepted and dropped.
// The output register holds one word, so a new word is taken while it drains.
module room_character_run_decoder_unit
  import rcrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_table_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [LOW_W-1:0]  out_room_id,
  output logic [CHAR_W-1:0] out_character_id,
  output logic              out_last_of_item
);

  localparam logic [1:0] S_HDR   = 2'd0;
  localparam logic [1:0] S_ENTRY = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_ENDED = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [LOW_W-1:0]  room_r, room_nxt;
  logic [CNT_W-1:0]  entries_r, entries_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [LOW_W-1:0]  oroom_r, oroom_nxt;
  logic [CHAR_W-1:0] ochar_r, ochar_nxt;
  logic              olast_r, olast_nxt;

  logic              accept;
  logic              out_free;
  logic [LOW_W-1:0]  word_low;
  logic [CNT_W-1:0]  word_top;
  run_ctrl_t         run_ctrl;
  run_status_t       run_status;

  assign word_low = in_table_word[LOW_W-1:0];
  assign word_top = in_table_word[WORD_W-1:LOW_W];
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r != S_RUN) && out_free;
  assign accept   = in_valid && in_ready;

  rcrd_run_unit u_run (
    .clk      (clk),
    .ctrl     (run_ctrl),
    .start_in (word_low),
    .len_in   (word_top),
    .status   (run_status)
  );

  always_comb begin
    state_nxt     = state_r;
    room_nxt      = room_r;
    entries_nxt   = entries_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    oroom_nxt     = oroom_r;
    ochar_nxt     = ochar_r;
    olast_nxt     = olast_r;
    run_ctrl      = '0;
    unique case (state_r)
      S_HDR: begin
        if (accept) begin
          if (in_table_word == END_WORD) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_END;
            oroom_nxt     = '0;
            ochar_nxt     = '0;
            olast_nxt     = 1'b1;
            state_nxt     = S_ENDED;
          end else begin
            room_nxt = word_low;
            if (word_top == '0) begin
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_EMPTY;
              oroom_nxt     = word_low;
              ochar_nxt     = '0;
              olast_nxt     = 1'b1;
            end else begin
              entries_nxt = word_top;
              state_nxt   = S_ENTRY;
            end
          end
        end
      end
      S_ENTRY: begin
        if (accept) begin
          entries_nxt   = entries_r - CNT_W'(1);
          run_ctrl.load = 1'b1;
          if (word_top == '0) begin
            state_nxt = (entries_r == CNT_W'(1)) ? S_HDR : S_ENTRY;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_CHAR;
          oroom_nxt     = room_r;
          ochar_nxt     = run_status.character;
          olast_nxt     = run_status.last;
          run_ctrl.step = 1'b1;
          if (run_status.last) begin
            state_nxt = (entries_r == '0) ? S_HDR : S_ENTRY;
          end
        end
      end
      S_ENDED: begin
        state_nxt = S_ENDED;
      end
      default: begin
        state_nxt = S_ENDED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HDR;
      room_r      <= '0;
      entries_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      room_r      <= room_nxt;
      entries_r   <= entries_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    oroom_r <= oroom_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_room_id      = oroom_r;
  assign out_character_id = ochar_r;
  assign out_last_of_item = olast_r;

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !in_ready)
    else $error("input taken during run");

  a_ended_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENDED) |=> !$rose(out_valid_r))
    else $error("word emitted after end of table");

  a_noncharacter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r != KIND_CHAR)) |-> ((ochar_r == '0) && olast_r))
    else $error("non-character word malformed");

  a_end_room_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == KIND_END)) |-> ((oroom_r == '0) && (state_r == S_ENDED)))
    else $error("end word malformed");

endmodule
